FILE: sv/strq_pkg.sv
`default_nettype none

package strq_pkg;

    localparam int DATA_W         = 32;
    localparam int KIND_W         = 2;
    localparam int INDEX_W        = 10;
    localparam int END_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 1;
    localparam int DEFAULT_LEAVES = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APPLY   = 1'd1;

    localparam logic COMB_MIN  = 1'b0;
    localparam logic COMB_SUM  = 1'b1;
    localparam logic APPLY_SET = 1'b0;
    localparam logic APPLY_ADD = 1'b1;

    localparam logic [DATA_W-1:0] MIN_IDENT = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SUM_IDENT = 32'h0000_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        STEP_CLEAR,
        STEP_IDLE,
        STEP_UPD_READ,
        STEP_UPD_LEAF,
        STEP_UPD_CLIMB,
        STEP_QRY_TEST,
        STEP_QRY_STEP,
        STEP_RD_READ,
        STEP_RD_LOAD,
        STEP_EMIT
    } step_t;

    typedef enum logic [1:0] {
        RA_LO,
        RA_LO_SIB,
        RA_PAR_SIB,
        RA_HI_DEC
    } rsel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_LEAF,
        WR_PARENT
    } wsel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LEAF,
        ACC_PARENT,
        ACC_LO_ODD,
        ACC_HI_TAKE,
        ACC_LOAD
    } accop_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_UP,
        PTR_QSTEP
    } ptrop_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_DISPATCH,
        BR_LO_GE4,
        BR_LO_GE_HI,
        BR_CLR_MORE,
        BR_OUT_BUSY
    } cond_t;

    typedef struct packed {
        rsel_t  rsel;
        wsel_t  wsel;
        accop_t accop;
        ptrop_t ptrop;
        logic   emit;
        cond_t  cond;
        step_t  target;
        logic   ret;
    } ctrl_t;

    typedef struct packed {
        logic idx_ok;
        logic q_ok;
        logic clr_start;
        logic lo_ge4;
        logic lo_ge_hi;
        logic clr_more;
        logic out_busy;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        rsel:   RA_LO,
        wsel:   WR_NONE,
        accop:  ACC_HOLD,
        ptrop:  PTR_HOLD,
        emit:   1'b0,
        cond:   BR_NEXT,
        target: STEP_IDLE,
        ret:    1'b0
    };

    function automatic logic [DATA_W-1:0] strq_ident(input logic op);
        return (op == COMB_SUM) ? SUM_IDENT : MIN_IDENT;
    endfunction

    function automatic logic [DATA_W-1:0] strq_combine(
        input logic              op,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        if (op == COMB_SUM)
        begin
            return a + b;
        end
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic logic [DATA_W-1:0] strq_apply(
        input logic              op,
        input logic [DATA_W-1:0] leaf,
        input logic [DATA_W-1:0] operand
    );
        return (op == APPLY_ADD) ? leaf + operand : operand;
    endfunction

endpackage

`default_nettype wire

FILE: sv/strq_datapath.sv
`default_nettype none

module strq_datapath #(
    parameter int LEAVES = strq_pkg::DEFAULT_LEAVES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire strq_pkg::ctrl_t                     ctrl,
    input  wire logic                                load,
    input  wire logic [strq_pkg::INDEX_W-1:0]        index,
    input  wire logic [strq_pkg::END_W-1:0]          range_end,
    input  wire logic signed [strq_pkg::DATA_W-1:0]  value,
    input  wire logic                                cfg_valid,
    input  wire logic [strq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [strq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic signed [strq_pkg::DATA_W-1:0]       answer,
    output strq_pkg::status_t                        status
);
    import strq_pkg::*;

    localparam int LW     = $clog2(LEAVES);
    localparam int PADDED = 1 << LW;
    localparam int AW     = LW + 1;
    localparam int PW     = LW + 2;
    localparam int DEPTH  = 1 << AW;
    localparam int CW     = (LW + 1 > END_W) ? LW + 1 : END_W;

    logic [DATA_W-1:0] node_mem [DEPTH];

    logic              comb_op_reg;
    logic              comb_op_next;
    logic              apply_op_reg;
    logic              apply_op_next;
    logic [PW-1:0]     lo_reg;
    logic [PW-1:0]     lo_next;
    logic [PW-1:0]     hi_reg;
    logic [PW-1:0]     hi_next;
    logic              hi_take_reg;
    logic              hi_take_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] answer_reg;

    logic [CW-1:0]     idx_c;
    logic [CW-1:0]     end_c;
    logic [CW-1:0]     endc;
    logic [CW-1:0]     leaves_c;
    logic              cfg_comb_wr;
    logic              cfg_apply_wr;
    logic              emit_fire;
    logic [DATA_W-1:0] ident;
    logic [DATA_W-1:0] leaf_val;
    logic [DATA_W-1:0] comb_val;
    logic [PW-1:0]     lo_half;
    logic [PW-1:0]     rd_ptr;
    logic [PW-1:0]     wr_ptr;
    logic              wr_en;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] wdata;

    assign idx_c    = CW'(index);
    assign end_c    = CW'(range_end);
    assign leaves_c = CW'(LEAVES);
    assign endc     = (end_c > leaves_c) ? leaves_c : end_c;

    assign cfg_comb_wr  = cfg_valid && (cfg_index == CFG_COMBINE);
    assign cfg_apply_wr = cfg_valid && (cfg_index == CFG_APPLY);

    assign ident    = strq_ident(comb_op_reg);
    assign leaf_val = strq_apply(apply_op_reg, rd_reg, val_reg);
    assign comb_val = strq_combine(comb_op_reg, acc_reg, rd_reg);
    assign lo_half  = lo_reg >> 1;

    assign status.idx_ok    = idx_c < leaves_c;
    assign status.q_ok      = idx_c < endc;
    assign status.clr_start = cfg_comb_wr;
    assign status.lo_ge4    = |lo_reg[PW-1:2];
    assign status.lo_ge_hi  = lo_reg >= hi_reg;
    assign status.clr_more  = lo_reg != PW'(DEPTH - 1);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign emit_fire = ctrl.emit && !status.out_busy;

    always_comb
    begin
        case (ctrl.rsel)
            RA_LO:      rd_ptr = lo_reg;
            RA_LO_SIB:  rd_ptr = lo_reg ^ PW'(1);
            RA_PAR_SIB: rd_ptr = lo_half ^ PW'(1);
            RA_HI_DEC:  rd_ptr = hi_reg - PW'(1);
            default:    rd_ptr = lo_reg;
        endcase
        raddr = rd_ptr[AW-1:0];
    end

    always_comb
    begin
        wr_en  = 1'b0;
        wr_ptr = lo_reg;
        wdata  = ident;
        case (ctrl.wsel)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_CLEAR:
            begin
                wr_en = 1'b1;
                wdata = ident;
            end
            WR_LEAF:
            begin
                wr_en = 1'b1;
                wdata = leaf_val;
            end
            WR_PARENT:
            begin
                wr_en  = 1'b1;
                wr_ptr = lo_half;
                wdata  = comb_val;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        waddr = wr_ptr[AW-1:0];
    end

    always_comb
    begin
        comb_op_next   = comb_op_reg;
        apply_op_next  = apply_op_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        hi_take_next   = hi_take_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;

        if (cfg_comb_wr)
        begin
            comb_op_next = cfg_data[0];
        end
        if (cfg_apply_wr)
        begin
            apply_op_next = cfg_data[0];
        end

        if (cfg_comb_wr)
        begin
            lo_next = '0;
        end
        else if (load)
        begin
            lo_next      = PW'(idx_c) + PW'(PADDED);
            hi_next      = PW'(endc) + PW'(PADDED);
            hi_take_next = 1'b0;
            acc_next     = ident;
        end
        else
        begin
            case (ctrl.ptrop)
                PTR_HOLD:
                begin
                    lo_next = lo_reg;
                end
                PTR_INC:
                begin
                    lo_next = lo_reg + PW'(1);
                end
                PTR_UP:
                begin
                    lo_next = lo_half;
                end
                PTR_QSTEP:
                begin
                    lo_next      = (lo_reg + PW'(lo_reg[0])) >> 1;
                    hi_next      = hi_reg >> 1;
                    hi_take_next = hi_reg[0];
                end
                default:
                begin
                    lo_next = lo_reg;
                end
            endcase

            case (ctrl.accop)
                ACC_HOLD:    acc_next = acc_reg;
                ACC_LEAF:    acc_next = leaf_val;
                ACC_PARENT:  acc_next = comb_val;
                ACC_LO_ODD:  acc_next = lo_reg[0] ? comb_val : acc_reg;
                ACC_HI_TAKE: acc_next = hi_take_reg ? comb_val : acc_reg;
                ACC_LOAD:    acc_next = rd_reg;
                default:     acc_next = acc_reg;
            endcase
        end

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_op_reg   <= COMB_MIN;
            apply_op_reg  <= APPLY_SET;
            lo_reg        <= '0;
            hi_take_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            comb_op_reg   <= comb_op_next;
            apply_op_reg  <= apply_op_next;
            lo_reg        <= lo_next;
            hi_take_reg   <= hi_take_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        acc_reg <= acc_next;
        if (load)
        begin
            val_reg <= value;
        end
        if (emit_fire)
        begin
            answer_reg <= acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[waddr] <= wdata;
        end
        rd_reg <= node_mem[raddr];
    end

    assign out_valid = out_valid_reg;
    assign answer    = $signed(answer_reg);

endmodule

`default_nettype wire

FILE: sv/strq_sequencer.sv
`default_nettype none

module strq_sequencer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [strq_pkg::KIND_W-1:0]  kind,
    input  wire logic                         cfg_valid,
    input  wire strq_pkg::status_t            status,
    output strq_pkg::ctrl_t                   ctrl,
    output logic                              in_ready,
    output strq_pkg::step_t                   step
);
    import strq_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    step_t dispatch_step;
    logic  taken;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        w = CTRL_NOP;
        case (s)
            STEP_CLEAR:
            begin
                w.wsel   = WR_CLEAR;
                w.ptrop  = PTR_INC;
                w.cond   = BR_CLR_MORE;
                w.target = STEP_CLEAR;
            end
            STEP_IDLE:
            begin
                w.cond = BR_DISPATCH;
            end
            STEP_UPD_READ:
            begin
                w.rsel = RA_LO;
            end
            STEP_UPD_LEAF:
            begin
                w.rsel  = RA_LO_SIB;
                w.wsel  = WR_LEAF;
                w.accop = ACC_LEAF;
            end
            STEP_UPD_CLIMB:
            begin
                w.rsel   = RA_PAR_SIB;
                w.wsel   = WR_PARENT;
                w.accop  = ACC_PARENT;
                w.ptrop  = PTR_UP;
                w.cond   = BR_LO_GE4;
                w.target = STEP_UPD_CLIMB;
                w.ret    = 1'b1;
            end
            STEP_QRY_TEST:
            begin
                w.rsel   = RA_LO;
                w.accop  = ACC_HI_TAKE;
                w.cond   = BR_LO_GE_HI;
                w.target = STEP_EMIT;
            end
            STEP_QRY_STEP:
            begin
                w.rsel   = RA_HI_DEC;
                w.accop  = ACC_LO_ODD;
                w.ptrop  = PTR_QSTEP;
                w.cond   = BR_ALWAYS;
                w.target = STEP_QRY_TEST;
            end
            STEP_RD_READ:
            begin
                w.rsel = RA_LO;
            end
            STEP_RD_LOAD:
            begin
                w.accop = ACC_LOAD;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = BR_OUT_BUSY;
                w.target = STEP_EMIT;
                w.ret    = 1'b1;
            end
            default:
            begin
                w.cond   = BR_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    assign ctrl     = ucode(upc_reg);
    assign in_ready = (upc_reg == STEP_IDLE) && !cfg_valid;
    assign step     = upc_reg;

    always_comb
    begin
        case (kind_t'(kind))
            KIND_UPDATE: dispatch_step = status.idx_ok ? STEP_UPD_READ : STEP_IDLE;
            KIND_QUERY:  dispatch_step = status.q_ok ? STEP_QRY_TEST : STEP_EMIT;
            KIND_READ:   dispatch_step = status.idx_ok ? STEP_RD_READ : STEP_EMIT;
            default:     dispatch_step = STEP_IDLE;
        endcase

        case (ctrl.cond)
            BR_NEXT:     taken = 1'b0;
            BR_ALWAYS:   taken = 1'b1;
            BR_DISPATCH: taken = 1'b0;
            BR_LO_GE4:   taken = status.lo_ge4;
            BR_LO_GE_HI: taken = status.lo_ge_hi;
            BR_CLR_MORE: taken = status.clr_more;
            BR_OUT_BUSY: taken = status.out_busy;
            default:     taken = 1'b0;
        endcase

        if (status.clr_start)
        begin
            upc_next = STEP_CLEAR;
        end
        else if (ctrl.cond == BR_DISPATCH)
        begin
            upc_next = accept ? dispatch_step : STEP_IDLE;
        end
        else if (taken)
        begin
            upc_next = ctrl.target;
        end
        else if (ctrl.ret)
        begin
            upc_next = STEP_IDLE;
        end
        else
        begin
            upc_next = step_t'(upc_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/segment_tree_range_query_core.sv
`default_nettype none

// Segment tree over LEAVES signed 32-bit values with point update (set or wrapping add) and
// range query (signed minimum or wrapping sum) over a half-open span, plus single leaf reads.
// The nodes live in one memory with a write port and a registered read port, and a small
// microcode table steps a shared datapath through each item, one item at a time. An update
// makes one memory step per tree level, and a query makes two node reads per level through
// the single read port. After reset, and after every write to the combine mode register, the
// block sweeps all 2 * padded-leaf-count nodes to the new identity, one node per cycle, and
// holds in_ready low meanwhile; configuration writes are always accepted.
module segment_tree_range_query_core #(
    parameter int LEAVES = strq_pkg::DEFAULT_LEAVES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [strq_pkg::KIND_W-1:0]         kind,
    input  wire logic [strq_pkg::INDEX_W-1:0]        index,
    input  wire logic [strq_pkg::END_W-1:0]          range_end,
    input  wire logic signed [strq_pkg::DATA_W-1:0]  value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [strq_pkg::DATA_W-1:0]       answer,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [strq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [strq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import strq_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    step_t   step;
    logic    in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;

    strq_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .kind      (kind),
        .cfg_valid (cfg_valid),
        .status    (status),
        .ctrl      (ctrl),
        .in_ready  (in_ready),
        .step      (step)
    );

    strq_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load      (in_accept),
        .index     (index),
        .range_end (range_end),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .answer    (answer),
        .status    (status)
    );

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (kind == KIND_QUERY) |=> !in_ready)
        else $error("query item accepted but block ready again at once");

    a_combine_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && (cfg_index == CFG_COMBINE) |=> (step == STEP_CLEAR) && !in_ready)
        else $error("combine mode write did not start a clearing sweep");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step == STEP_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

`default_nettype wire
